### src/acet_pkg.sv
// ----------------------------------------------------------------------------
// acet_pkg
// Shared types and codes for the box contact event tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package acet_pkg;

    // contact event codes
    typedef logic [1:0] t_event;

    localparam t_event EV_NONE  = 2'd0;
    localparam t_event EV_ENTER = 2'd1;
    localparam t_event EV_STAY  = 2'd2;
    localparam t_event EV_EXIT  = 2'd3;

    // per-pair flags carried from the accept cycle to the table update cycle
    typedef struct packed {
        logic self_pair;
        logic dead;
    } t_pair_flags;

endpackage

`default_nettype wire

### src/acet_ram.sv
// ----------------------------------------------------------------------------
// acet_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module acet_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/acet_overlap.sv
// ----------------------------------------------------------------------------
// acet_overlap
// Two-axis box overlap test: differences and size sums are registered on
// accept, the absolute-value compare follows in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acet_overlap #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic signed [COORD_BITS-1:0] i_left_x,
    input  wire logic signed [COORD_BITS-1:0] i_left_y,
    input  wire logic        [COORD_BITS-2:0] i_left_w,
    input  wire logic        [COORD_BITS-2:0] i_left_h,
    input  wire logic signed [COORD_BITS-1:0] i_right_x,
    input  wire logic signed [COORD_BITS-1:0] i_right_y,
    input  wire logic        [COORD_BITS-2:0] i_right_w,
    input  wire logic        [COORD_BITS-2:0] i_right_h,
    output logic                              o_overlap
);

    localparam int DW = COORD_BITS + 1;  // centre difference
    localparam int CW = COORD_BITS + 2;  // doubled distance

    logic signed [DW-1:0]         r_dx;
    logic signed [DW-1:0]         r_dy;
    logic        [COORD_BITS-1:0] r_sw;
    logic        [COORD_BITS-1:0] r_sh;

    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
    logic          ov_x;
    logic          ov_y;

    // first stage: signed differences and size sums
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dx <= DW'(i_right_x) - DW'(i_left_x);
            r_dy <= DW'(i_right_y) - DW'(i_left_y);
            r_sw <= COORD_BITS'(i_left_w) + COORD_BITS'(i_right_w);
            r_sh <= COORD_BITS'(i_left_h) + COORD_BITS'(i_right_h);
        end
    end

    // second stage: twice the absolute distance against the size sum
    always_comb begin
        ax        = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        ay        = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
        ov_x      = {ax, 1'b0} <= CW'(r_sw);
        ov_y      = {ay, 1'b0} <= CW'(r_sh);
        o_overlap = ov_x && ov_y;
    end

endmodule

`default_nettype wire

### src/aabb_contact_event_tracker.sv
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker
// Box overlap test on an ordered collider pair with a per-pair contact bit
// table that turns the overlap history into enter, stay and exit events.
//
//   channel  | handshake      | payload
//   ---------+----------------+---------------------------------------------
//   pair in  | start / busy   | ids, centres, sizes, dead flags
//   event out| o_valid strobe | o_contact_event, o_boxes_overlap
//
// One pair is taken per cycle while busy is low; its result appears for one
// cycle after the registered read of the contact table RAM and the update
// and output register; a pair that repeats the previous one gets the fresh
// contact bit through forwarding.
// After reset a clearing pass writes all MAX_COLLIDERS**2 table entries
// with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_contact_event_tracker #(
    parameter int MAX_COLLIDERS = 64,
    parameter int COORD_BITS    = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [$clog2(MAX_COLLIDERS)-1:0] i_left_id,
    input  wire logic        [$clog2(MAX_COLLIDERS)-1:0] i_right_id,
    input  wire logic signed [COORD_BITS-1:0]         i_left_x,
    input  wire logic signed [COORD_BITS-1:0]         i_left_y,
    input  wire logic        [COORD_BITS-2:0]         i_left_w,
    input  wire logic        [COORD_BITS-2:0]         i_left_h,
    input  wire logic signed [COORD_BITS-1:0]         i_right_x,
    input  wire logic signed [COORD_BITS-1:0]         i_right_y,
    input  wire logic        [COORD_BITS-2:0]         i_right_w,
    input  wire logic        [COORD_BITS-2:0]         i_right_h,
    input  wire logic                                 i_left_dead,
    input  wire logic                                 i_right_dead,
    output logic                                      o_valid,
    output acet_pkg::t_event                          o_contact_event,
    output logic                                      o_boxes_overlap
);

    localparam int IW    = $clog2(MAX_COLLIDERS);
    localparam int DEPTH = MAX_COLLIDERS * MAX_COLLIDERS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [IW:0]   MAX_ID   = (IW + 1)'(MAX_COLLIDERS);
    localparam logic [IW-1:0] ID_WRAP  = IW'(MAX_COLLIDERS);
    localparam logic [AW-1:0] ROW_LEN  = AW'(MAX_COLLIDERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // clearing pass
    logic          r_clearing;
    logic [AW-1:0] r_clr_cnt;

    // update stage
    logic                  r_s1_valid;
    logic [AW-1:0]         r_s1_idx;
    acet_pkg::t_pair_flags r_s1_flags;

    // forwarding of the last table write
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_idx;
    logic          r_fwd_bit;

    logic            accept;
    logic [IW-1:0]   lid;
    logic [IW-1:0]   rid;
    logic [AW-1:0]   idx;
    logic            ram_rdata;
    logic            overlap;
    logic            contact;
    logic            new_bit;
    acet_pkg::t_event ev;
    logic            item_we;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic            ram_wdata;

    assign busy   = r_clearing;
    assign accept = start && !busy;

    // ids wrapped into range and the pair's table index
    always_comb begin
        lid = ({1'b0, i_left_id} >= MAX_ID) ? i_left_id - ID_WRAP : i_left_id;
        rid = ({1'b0, i_right_id} >= MAX_ID) ? i_right_id - ID_WRAP : i_right_id;
        idx = AW'(lid) * ROW_LEN + AW'(rid);
    end

    // clearing pass after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
            if (r_clr_cnt == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // overlap test, result lines up with the table read
    acet_overlap #(
        .COORD_BITS (COORD_BITS)
    ) u_overlap (
        .i_clk     (i_clk),
        .i_load    (accept),
        .i_left_x  (i_left_x),
        .i_left_y  (i_left_y),
        .i_left_w  (i_left_w),
        .i_left_h  (i_left_h),
        .i_right_x (i_right_x),
        .i_right_y (i_right_y),
        .i_right_w (i_right_w),
        .i_right_h (i_right_h),
        .o_overlap (overlap)
    );

    // contact bit table
    acet_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (idx),
        .o_rdata (ram_rdata)
    );

    // update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx             <= idx;
            r_s1_flags.self_pair <= (lid == rid);
            r_s1_flags.dead      <= i_left_dead || i_right_dead;
        end
    end

    // event decision on the current contact bit
    always_comb begin
        contact = (r_fwd_valid && r_fwd_idx == r_s1_idx) ? r_fwd_bit : ram_rdata;
        new_bit = contact;
        ev      = acet_pkg::EV_NONE;
        if (!r_s1_flags.self_pair) begin
            if (overlap) begin
                if (contact) begin
                    if (r_s1_flags.dead) begin
                        ev      = acet_pkg::EV_EXIT;
                        new_bit = 1'b0;
                    end else begin
                        ev = acet_pkg::EV_STAY;
                    end
                end else if (!r_s1_flags.dead) begin
                    ev      = acet_pkg::EV_ENTER;
                    new_bit = 1'b1;
                end
            end else if (contact) begin
                ev      = acet_pkg::EV_EXIT;
                new_bit = 1'b0;
            end
        end
        item_we = r_s1_valid && (new_bit != contact);
    end

    // table write mux: clearing pass or write-back
    always_comb begin
        ram_we    = r_clearing || item_we;
        ram_waddr = r_clearing ? r_clr_cnt : r_s1_idx;
        ram_wdata = r_clearing ? 1'b0 : new_bit;
    end

    // remember the write that the next read cannot see yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= item_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            r_fwd_idx <= r_s1_idx;
            r_fwd_bit <= new_bit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            o_contact_event <= ev;
            o_boxes_overlap <= overlap;
        end
    end

    // clearing pass runs once after reset
    a_busy_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose again after the clearing pass");

    // every result follows a pair transfer
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 2))
        else $error("result strobe without a pair transfer");

    // a self pair never reports an event
    a_self_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_left_id == i_right_id, 2))
            |-> o_contact_event == acet_pkg::EV_NONE)
        else $error("event reported for a self pair");

    // a dead object never enters contact
    a_dead_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_left_dead || i_right_dead, 2))
            |-> o_contact_event != acet_pkg::EV_ENTER)
        else $error("enter event with a dead object");

endmodule

`default_nettype wire
